// ----- rtl/core/bfha_pkg.sv -----
// shared types and constants of the best-fit heap allocator
// no dependencies
package bfha_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 24;
  localparam int NEED_W     = 25;
  localparam int FREE_W     = 25;
  localparam int HINT_W     = 26;

  localparam logic [ADDR_W-1:0] HDR_BYTES = 32'h10;
  localparam logic [NEED_W-1:0] ROUND_ADD = 25'h17;
  localparam logic [LEN_W-1:0]  SPLIT_MIN = 24'h11;
  localparam logic [LEN_W-1:0]  LEN_MAX   = 24'hFFFFFF;

  localparam logic [ADDR_W-1:0] R0_BASE_RST = 32'h8025D800;
  localparam logic [ADDR_W-1:0] R0_END_RST  = 32'h802EA000;
  localparam logic [ADDR_W-1:0] R1_BASE_RST = 32'h80600000;
  localparam logic [ADDR_W-1:0] R1_END_RST  = 32'h80800000;

  localparam logic [2:0] REQ_ALLOC  = 3'd0;
  localparam logic [2:0] REQ_FREE   = 3'd1;
  localparam logic [2:0] REQ_RESCAN = 3'd2;
  localparam logic [2:0] REQ_INIT   = 3'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NULL  = 2'd2;

  localparam logic [2:0] CFG_R0_BASE = 3'd0;
  localparam logic [2:0] CFG_R0_END  = 3'd1;
  localparam logic [2:0] CFG_R1_EN   = 3'd2;
  localparam logic [2:0] CFG_R1_BASE = 3'd3;
  localparam logic [2:0] CFG_R1_END  = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              start_we;
    idx_t              start_addr;
    logic [ADDR_W-1:0] start_data;
    logic              len_we;
    idx_t              len_addr;
    logic [LEN_W-1:0]  len_data;
    logic              used_we;
    idx_t              used_addr;
    logic              used_data;
    logic              next_we;
    idx_t              next_addr;
    idx_t              next_data;
    logic              prev_we;
    idx_t              prev_addr;
    idx_t              prev_data;
    logic              set_valid;
    idx_t              set_idx;
    logic              clr_valid;
    idx_t              clr_idx;
    logic              clear_all;
    idx_t              rd_addr;
  } tbl_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic              used;
    idx_t              next;
    idx_t              prev;
  } tbl_rd_t;

endpackage

// ----- rtl/core/bfha_table.sv -----
// block table: field memories with one write and one registered read each,
// entry valid flops and lowest free slot pick; uses bfha_pkg
module bfha_table (
  input  logic              clk,
  input  logic              rst,
  input  bfha_pkg::tbl_ctl_t ctl,
  output bfha_pkg::tbl_rd_t  rd,
  output bfha_pkg::idx_t     slot,
  output logic              slot_ok
);
  import bfha_pkg::*;

  logic [ADDR_W-1:0] start_mem [MAX_BLOCKS];
  logic [LEN_W-1:0]  len_mem   [MAX_BLOCKS];
  logic              used_mem  [MAX_BLOCKS];
  idx_t              next_mem  [MAX_BLOCKS];
  idx_t              prev_mem  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid;
  logic [MAX_BLOCKS-1:0] valid_next;

  always_ff @(posedge clk) begin
    if (ctl.start_we) start_mem[ctl.start_addr] <= ctl.start_data;
    if (ctl.len_we)   len_mem[ctl.len_addr]     <= ctl.len_data;
    if (ctl.used_we)  used_mem[ctl.used_addr]   <= ctl.used_data;
    if (ctl.next_we)  next_mem[ctl.next_addr]   <= ctl.next_data;
    if (ctl.prev_we)  prev_mem[ctl.prev_addr]   <= ctl.prev_data;
    rd.start <= start_mem[ctl.rd_addr];
    rd.len   <= len_mem[ctl.rd_addr];
    rd.used  <= used_mem[ctl.rd_addr];
    rd.next  <= next_mem[ctl.rd_addr];
    rd.prev  <= prev_mem[ctl.rd_addr];
    rd.valid <= valid[ctl.rd_addr];
  end

  always_comb begin
    valid_next = ctl.clear_all ? '0 : valid;
    if (ctl.clr_valid) valid_next[ctl.clr_idx] = 1'b0;
    if (ctl.set_valid) valid_next[ctl.set_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_comb begin
    slot = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid[i]) slot = IDX_W'(i);
    end
    slot_ok = ~&valid;
  end

endmodule

// ----- rtl/core/best_fit_heap_allocator_unit.sv -----
// best-fit heap allocator top level: request sequencer and result register
// depends on bfha_pkg and bfha_table
// Each request is taken in the idle state and answered with one result. Alloc and
// rescan walk the block list one entry per cycle through the table's registered read
// port; free scans the table by index, one entry per cycle, then merges the block with
// its previous and next neighbors; init rebuilds the table from the region registers.
// The next request is taken while a finished result still waits on the output.
module best_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [23:0] request_bytes,
  input  logic [31:0] payload_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] block_addr,
  output logic [24:0] free_total,
  output logic signed [25:0] largest_free,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bfha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_WDONE, S_SPLIT2, S_F_START, S_F_SCAN, S_F_PV,
    S_F_NX, S_F_NXD, S_F_END, S_INIT0, S_INIT1, S_FINISH
  } state_t;

  state_t state;
  tbl_ctl_t ctl;
  tbl_rd_t  rd;
  idx_t     slot;
  logic     slot_ok;

  logic [ADDR_W-1:0] r0_base, r0_end, r1_base, r1_end;
  logic              r1_en;

  logic [2:0]        req;
  logic [NEED_W-1:0] need;
  logic [ADDR_W-1:0] want;
  idx_t              head, tail, p, q, best, best_next, new_slot;
  logic [CNT_W-1:0]  count, k;
  logic [FREE_W-1:0] free_bytes;
  logic [HINT_W-1:0] hint;
  logic              found, split_mid;
  logic [ADDR_W-1:0] best_start;
  logic [LEN_W-1:0]  best_len, spare_len, len0;
  idx_t              cur, cur_next, cur_prev;
  logic [ADDR_W-1:0] cur_start;
  logic [LEN_W-1:0]  cur_len;
  logic [1:0]        st_r;
  logic [ADDR_W-1:0] addr_r;

  logic              w_fit, w_better, hit, pv_merge, nx_merge, ok0, ok1;
  logic [LEN_W-1:0]  w_t, w_d, w_rem, w_rem_scan, rem, pv_sum, nx_sum;
  logic [LEN_W-1:0]  l0, l1, cap1;
  logic [ADDR_W-1:0] d0, d1;

  bfha_table u_table (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd     (rd),
    .slot   (slot),
    .slot_ok(slot_ok)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r0_base <= R0_BASE_RST;
      r0_end  <= R0_END_RST;
      r1_en   <= 1'b0;
      r1_base <= R1_BASE_RST;
      r1_end  <= R1_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_R0_BASE: r0_base <= cfg_data;
        CFG_R0_END:  r0_end  <= cfg_data;
        CFG_R1_EN:   r1_en   <= cfg_data[0];
        CFG_R1_BASE: r1_base <= cfg_data;
        CFG_R1_END:  r1_end  <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    w_fit    = !rd.used && ({1'b0, rd.len} >= need);
    w_better = !found || (rd.len < best_len);
    w_t      = (found && (spare_len < best_len)) ? best_len : spare_len;
    w_d      = rd.len - need[LEN_W-1:0];
    if (w_better) begin
      w_rem = (w_t < w_d) ? w_d : w_t;
    end else begin
      w_rem = (spare_len < rd.len) ? rd.len : spare_len;
    end
    w_rem_scan = (!rd.used && (spare_len < rd.len)) ? rd.len : spare_len;
    rem      = best_len - need[LEN_W-1:0];
    hit      = rd.valid && rd.used && (rd.start == want);
    pv_sum   = rd.len + cur_len;
    pv_merge = !rd.used && (rd.start + ADDR_W'(rd.len) == cur_start);
    nx_sum   = cur_len + rd.len;
    nx_merge = !rd.used && (cur_start + ADDR_W'(cur_len) == rd.start);
    d0   = r0_end - r0_base;
    ok0  = r0_end > r0_base;
    l0   = (d0 > ADDR_W'(LEN_MAX)) ? LEN_MAX : d0[LEN_W-1:0];
    cap1 = LEN_MAX - len0;
    d1   = r1_end - r1_base;
    l1   = (d1 > ADDR_W'(cap1)) ? cap1 : d1[LEN_W-1:0];
    ok1  = r1_en && (r1_end > r1_base) && (l1 != '0);
  end

  // table control
  always_comb begin
    ctl = '0;
    ctl.rd_addr = head;
    unique case (state)
      S_WALK: ctl.rd_addr = rd.next;
      S_WDONE: begin
        if (req == REQ_ALLOC && found) begin
          if (rem >= SPLIT_MIN && slot_ok) begin
            ctl.start_we   = 1'b1;
            ctl.start_addr = slot;
            ctl.start_data = best_start + ADDR_W'(need);
            ctl.len_we     = 1'b1;
            ctl.len_addr   = slot;
            ctl.len_data   = rem;
            ctl.used_we    = 1'b1;
            ctl.used_addr  = slot;
            ctl.used_data  = 1'b0;
            ctl.next_we    = 1'b1;
            ctl.next_addr  = slot;
            ctl.next_data  = best_next;
            ctl.prev_we    = 1'b1;
            ctl.prev_addr  = slot;
            ctl.prev_data  = best;
            ctl.set_valid  = 1'b1;
            ctl.set_idx    = slot;
          end else begin
            ctl.used_we   = 1'b1;
            ctl.used_addr = best;
            ctl.used_data = 1'b1;
          end
        end
      end
      S_SPLIT2: begin
        ctl.len_we    = 1'b1;
        ctl.len_addr  = best;
        ctl.len_data  = need[LEN_W-1:0];
        ctl.used_we   = 1'b1;
        ctl.used_addr = best;
        ctl.used_data = 1'b1;
        ctl.next_we   = 1'b1;
        ctl.next_addr = best;
        ctl.next_data = new_slot;
        ctl.prev_we   = split_mid;
        ctl.prev_addr = best_next;
        ctl.prev_data = new_slot;
      end
      S_F_START: ctl.rd_addr = '0;
      S_F_SCAN: ctl.rd_addr = hit ? rd.prev : q + 1'b1;
      S_F_PV: begin
        if (pv_merge) begin
          ctl.len_we    = 1'b1;
          ctl.len_addr  = cur_prev;
          ctl.len_data  = pv_sum;
          ctl.next_we   = 1'b1;
          ctl.next_addr = cur_prev;
          ctl.next_data = cur_next;
          ctl.prev_we   = (cur != tail);
          ctl.prev_addr = cur_next;
          ctl.prev_data = cur_prev;
          ctl.clr_valid = 1'b1;
          ctl.clr_idx   = cur;
        end
      end
      S_F_NX: ctl.rd_addr = cur_next;
      S_F_NXD: begin
        if (nx_merge) begin
          ctl.len_we    = 1'b1;
          ctl.len_addr  = cur;
          ctl.len_data  = nx_sum;
          ctl.next_we   = 1'b1;
          ctl.next_addr = cur;
          ctl.next_data = rd.next;
          ctl.prev_we   = (cur_next != tail);
          ctl.prev_addr = rd.next;
          ctl.prev_data = cur;
          ctl.clr_valid = 1'b1;
          ctl.clr_idx   = cur_next;
        end
      end
      S_F_END: begin
        ctl.used_we   = 1'b1;
        ctl.used_addr = cur;
        ctl.used_data = 1'b0;
      end
      S_INIT0: begin
        ctl.clear_all  = 1'b1;
        ctl.start_we   = ok0;
        ctl.start_addr = '0;
        ctl.start_data = r0_base;
        ctl.len_we     = ok0;
        ctl.len_addr   = '0;
        ctl.len_data   = l0;
        ctl.used_we    = ok0;
        ctl.used_addr  = '0;
        ctl.used_data  = 1'b0;
        ctl.set_valid  = ok0;
        ctl.set_idx    = '0;
      end
      S_INIT1: begin
        ctl.start_we   = ok1;
        ctl.start_addr = count[IDX_W-1:0];
        ctl.start_data = r1_base;
        ctl.len_we     = ok1;
        ctl.len_addr   = count[IDX_W-1:0];
        ctl.len_data   = l1;
        ctl.used_we    = ok1;
        ctl.used_addr  = count[IDX_W-1:0];
        ctl.used_data  = 1'b0;
        ctl.set_valid  = ok1;
        ctl.set_idx    = count[IDX_W-1:0];
        ctl.next_we    = ok1 && (count != '0);
        ctl.next_addr  = tail;
        ctl.next_data  = count[IDX_W-1:0];
        ctl.prev_we    = ok1 && (count != '0);
        ctl.prev_addr  = count[IDX_W-1:0];
        ctl.prev_data  = tail;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      free_bytes <= '0;
      hint       <= '1;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req       <= req_type;
            need      <= ({1'b0, request_bytes} + ROUND_ADD) & ~NEED_W'(7);
            want      <= payload_addr - HDR_BYTES;
            st_r      <= ST_OK;
            addr_r    <= '0;
            p         <= head;
            k         <= CNT_W'(1);
            found     <= 1'b0;
            spare_len <= '0;
            case (req_type) inside
              REQ_ALLOC, REQ_RESCAN: begin
                if (count == '0) begin
                  hint  <= '0;
                  if (req_type == REQ_ALLOC) st_r <= ST_NOFIT;
                  state <= S_FINISH;
                end else begin
                  state <= S_WALK;
                end
              end
              REQ_FREE: begin
                if (payload_addr == '0) begin
                  st_r  <= ST_NULL;
                  state <= S_FINISH;
                end else begin
                  state <= S_F_START;
                end
              end
              REQ_INIT: state <= S_INIT0;
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_WALK: begin
          if (req == REQ_ALLOC) begin
            if (w_fit) begin
              spare_len <= w_rem;
              if (w_better) begin
                best_len   <= rd.len;
                best       <= p;
                best_start <= rd.start;
                best_next  <= rd.next;
                found      <= 1'b1;
              end
            end
          end else begin
            spare_len <= w_rem_scan;
          end
          p <= rd.next;
          k <= k + 1'b1;
          if (k == count) state <= S_WDONE;
        end
        S_WDONE: begin
          hint <= HINT_W'(spare_len);
          state <= S_FINISH;
          if (req == REQ_ALLOC) begin
            if (!found) begin
              st_r <= ST_NOFIT;
            end else begin
              addr_r <= best_start + HDR_BYTES;
              if (rem >= SPLIT_MIN && slot_ok) begin
                new_slot   <= slot;
                split_mid  <= (best != tail);
                if (best == tail) tail <= slot;
                count      <= count + 1'b1;
                free_bytes <= free_bytes - need;
                state      <= S_SPLIT2;
              end else begin
                free_bytes <= free_bytes - FREE_W'(best_len);
              end
            end
          end
        end
        S_SPLIT2: state <= S_FINISH;
        S_F_START: begin
          q     <= '0;
          state <= S_F_SCAN;
        end
        S_F_SCAN: begin
          q <= q + 1'b1;
          if (hit) begin
            cur        <= q;
            cur_start  <= rd.start;
            cur_len    <= rd.len;
            cur_next   <= rd.next;
            cur_prev   <= rd.prev;
            free_bytes <= free_bytes + FREE_W'(rd.len);
            state      <= (q != head) ? S_F_PV : S_F_NX;
          end else if (q == idx_t'(MAX_BLOCKS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_F_PV: begin
          if (pv_merge) begin
            if (cur == tail) tail <= cur_prev;
            count     <= count - 1'b1;
            cur       <= cur_prev;
            cur_start <= rd.start;
            cur_len   <= pv_sum;
          end
          state <= S_F_NX;
        end
        S_F_NX: state <= (cur != tail) ? S_F_NXD : S_F_END;
        S_F_NXD: begin
          if (nx_merge) begin
            if (cur_next == tail) tail <= cur;
            count <= count - 1'b1;
          end
          state <= S_F_END;
        end
        S_F_END: state <= S_FINISH;
        S_INIT0: begin
          head  <= '0;
          tail  <= '0;
          hint  <= '1;
          count <= ok0 ? CNT_W'(1) : '0;
          free_bytes <= ok0 ? FREE_W'(l0) : '0;
          len0  <= ok0 ? l0 : '0;
          state <= S_INIT1;
        end
        S_INIT1: begin
          if (ok1) begin
            if (count == '0) head <= '0;
            tail       <= count[IDX_W-1:0];
            count      <= count + 1'b1;
            free_bytes <= free_bytes + FREE_W'(l1);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= st_r;
            block_addr   <= addr_r;
            free_total   <= free_bytes;
            largest_free <= hint;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS)) else $error("block count above table size");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> count != '0) else $error("list walk on empty list");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail) else $error("empty list with split ends");

endmodule
